// File: rtl/pab_pkg.sv
// Shared types and constants for the polygon area and bounds core.
package pab_pkg;

   localparam int COORD_W       = 16;
   localparam int TERM_W        = 17;
   localparam int PROD_W        = 34;
   localparam int AREA_W        = 44;
   localparam int COUNT_FIELD_W = 11;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

   // one classified vertex, as handed from front to back
   typedef struct packed {
      logic                      first;
      logic                      last;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [TERM_W-1:0]  ax;
      logic signed [TERM_W-1:0]  ay;
      logic signed [TERM_W-1:0]  cx;
      logic signed [TERM_W-1:0]  cy;
   } vertex_entry_type;

   typedef struct packed {
      logic signed [AREA_W-1:0]        area_doubled;
      logic signed [COORD_W-1:0]       min_x;
      logic signed [COORD_W-1:0]       max_x;
      logic signed [COORD_W-1:0]       min_y;
      logic signed [COORD_W-1:0]       max_y;
      logic        [COUNT_FIELD_W-1:0] vertex_count;
      logic                            too_many;
   } result_word_type;

endpackage

// File: rtl/pab_if.sv
// Valid/ready channel interfaces for vertex and result words.
interface pab_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pab_pkg::COORD_W-1:0]  vertex_x;
   logic signed [pab_pkg::COORD_W-1:0]  vertex_y;
   logic                                last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface pab_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pab_pkg::AREA_W-1:0]        area_doubled;
   logic signed [pab_pkg::COORD_W-1:0]       min_x;
   logic signed [pab_pkg::COORD_W-1:0]       max_x;
   logic signed [pab_pkg::COORD_W-1:0]       min_y;
   logic signed [pab_pkg::COORD_W-1:0]       max_y;
   logic        [pab_pkg::COUNT_FIELD_W-1:0] vertex_count;
   logic                                     too_many;

   modport source (output valid, output area_doubled, output min_x, output max_x,
                   output min_y, output max_y, output vertex_count, output too_many,
                   input ready);
   modport sink   (input valid, input area_doubled, input min_x, input max_x,
                   input min_y, input max_y, input vertex_count, input too_many,
                   output ready);
endinterface

// File: rtl/polygon_area_and_bounds_core.sv
// Polygon shoelace area and bounding box core, top level.
// Throughput: one vertex word per cycle, sustained, including back to back polygons,
// unless a result word held by the receiver stalls the pipeline. The last vertex passes
// queue write, the 17x17 multiply stage and the accumulate stage into the result register.
// A four-entry queue decouples vertex intake from the multiply/accumulate pipeline.
// Reset (synchronous) empties the queue and pipeline and waits for a first vertex.
module polygon_area_and_bounds_core #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   pab_req_if.sink    req_ch,
   pab_rsp_if.source  rsp_ch
);

   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   pab_pkg::vertex_entry_type  push_entry, pop_entry;
   pab_pkg::result_word_type   out_word;

   pab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   pab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   pab_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (out_word)
   );

   assign rsp_ch.area_doubled = out_word.area_doubled;
   assign rsp_ch.min_x        = out_word.min_x;
   assign rsp_ch.max_x        = out_word.max_x;
   assign rsp_ch.min_y        = out_word.min_y;
   assign rsp_ch.max_y        = out_word.max_y;
   assign rsp_ch.vertex_count = out_word.vertex_count;
   assign rsp_ch.too_many     = out_word.too_many;

endmodule

// File: rtl/pab_front.sv
// Front end: accepts vertex words, tracks first/previous vertex, forms term operands.
module pab_front (
   input  logic                       clock,
   input  logic                       reset,
   pab_req_if.sink                    req_ch,
   output logic                       push_valid,
   input  logic                       push_ready,
   output pab_pkg::vertex_entry_type  push_entry
);

   logic                               active_ff, active_in;
   logic signed [pab_pkg::COORD_W-1:0] first_x_ff, first_x_in;
   logic signed [pab_pkg::COORD_W-1:0] first_y_ff, first_y_in;
   logic signed [pab_pkg::COORD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [pab_pkg::COORD_W-1:0] prev_y_ff, prev_y_in;
   logic signed [pab_pkg::COORD_W-1:0] fx, fy;
   logic                               take;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign take         = req_ch.valid && push_ready;

   assign fx = active_ff ? first_x_ff : req_ch.vertex_x;
   assign fy = active_ff ? first_y_ff : req_ch.vertex_y;

   always_comb begin
      push_entry.first = !active_ff;
      push_entry.last  = req_ch.last_vertex;
      push_entry.x     = req_ch.vertex_x;
      push_entry.y     = req_ch.vertex_y;
      push_entry.ax    = {prev_x_ff[15], prev_x_ff} + {req_ch.vertex_x[15], req_ch.vertex_x};
      push_entry.ay    = {prev_y_ff[15], prev_y_ff} - {req_ch.vertex_y[15], req_ch.vertex_y};
      push_entry.cx    = {req_ch.vertex_x[15], req_ch.vertex_x} + {fx[15], fx};
      push_entry.cy    = {req_ch.vertex_y[15], req_ch.vertex_y} - {fy[15], fy};
   end

   always_comb begin
      active_in  = active_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (take) begin
         active_in  = !req_ch.last_vertex;
         first_x_in = fx;
         first_y_in = fy;
         prev_x_in  = req_ch.vertex_x;
         prev_y_in  = req_ch.vertex_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

endmodule

// File: rtl/pab_queue.sv
// Short FIFO between front and back ends.
module pab_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  pab_pkg::vertex_entry_type  push_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output pab_pkg::vertex_entry_type  pop_entry
);

   pab_pkg::vertex_entry_type         slot_ff [pab_pkg::QUEUE_DEPTH];
   logic [pab_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pab_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pab_pkg::QUEUE_AW:0]        fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign push_ready = (fill_ff != (pab_pkg::QUEUE_AW+1)'(pab_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/pab_back.sv
// Back end: multiply stage, accumulate/box/count stage and result register.
module pab_back #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  pab_pkg::vertex_entry_type  pop_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pab_pkg::result_word_type   out_word
);

   localparam int CNT_RAW = $clog2(MAX_VERTICES + 1);
   localparam int CNT_W   = (CNT_RAW > pab_pkg::COUNT_FIELD_W) ? CNT_RAW
                                                               : pab_pkg::COUNT_FIELD_W;
   localparam int AW      = pab_pkg::AREA_W;
   localparam int PW      = pab_pkg::PROD_W;
   localparam int CW      = pab_pkg::COORD_W;

   // multiply stage
   logic                  m_valid_ff, m_valid_in;
   logic                  m_first_ff, m_last_ff;
   logic signed [CW-1:0]  m_x_ff, m_y_ff;
   logic signed [PW-1:0]  m_pa_ff, m_pc_ff;
   logic signed [PW-1:0]  pa, pc;

   // accumulate stage state
   logic signed [AW-1:0]  area_ff, area_in;
   logic signed [CW-1:0]  min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [CW-1:0]  min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;

   logic                  o_valid_ff, o_valid_in;
   pab_pkg::result_word_type o_word_ff, o_word_in;

   logic                  adv_acc, adv_mul;
   logic [AW-1:0]         term_a, term_c, base;

   assign adv_acc   = m_valid_ff && (!m_last_ff || !o_valid_ff || out_ready);
   assign adv_mul   = !m_valid_ff || adv_acc;
   assign pop_ready = adv_mul;

   assign pa = $signed(pop_entry.ax) * $signed(pop_entry.ay);
   assign pc = $signed(pop_entry.cx) * $signed(pop_entry.cy);

   always_comb begin
      m_valid_in = m_valid_ff;
      if (adv_mul) begin
         m_valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_mul && pop_valid) begin
         m_first_ff <= pop_entry.first;
         m_last_ff  <= pop_entry.last;
         m_x_ff     <= pop_entry.x;
         m_y_ff     <= pop_entry.y;
         m_pa_ff    <= pa;
         m_pc_ff    <= pc;
      end
   end

   assign term_a = m_first_ff ? '0 : {{(AW-PW){m_pa_ff[PW-1]}}, m_pa_ff};
   assign term_c = m_last_ff  ? {{(AW-PW){m_pc_ff[PW-1]}}, m_pc_ff} : '0;
   assign base   = m_first_ff ? '0 : area_ff;

   always_comb begin
      area_in  = area_ff;
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (adv_acc) begin
         area_in = $signed(base + term_a + term_c);
         if (m_first_ff) begin
            min_x_in = m_x_ff;
            max_x_in = m_x_ff;
            min_y_in = m_y_ff;
            max_y_in = m_y_ff;
            count_in = CNT_W'(1);
            ovf_in   = 1'b0;
         end else begin
            min_x_in = (m_x_ff < min_x_ff) ? m_x_ff : min_x_ff;
            max_x_in = (m_x_ff > max_x_ff) ? m_x_ff : max_x_ff;
            min_y_in = (m_y_ff < min_y_ff) ? m_y_ff : min_y_ff;
            max_y_in = (m_y_ff > max_y_ff) ? m_y_ff : max_y_ff;
            if (count_ff >= CNT_W'(MAX_VERTICES)) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      o_word_in  = o_word_ff;
      if (o_valid_ff && out_ready) begin
         o_valid_in = 1'b0;
      end
      if (adv_acc && m_last_ff) begin
         o_valid_in             = 1'b1;
         o_word_in.area_doubled = -area_in;
         o_word_in.min_x        = min_x_in;
         o_word_in.max_x        = max_x_in;
         o_word_in.min_y        = min_y_in;
         o_word_in.max_y        = max_y_in;
         o_word_in.vertex_count =
            (count_in > CNT_W'({pab_pkg::COUNT_FIELD_W{1'b1}}))
            ? {pab_pkg::COUNT_FIELD_W{1'b1}} : count_in[pab_pkg::COUNT_FIELD_W-1:0];
         o_word_in.too_many     = ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
      end
      area_ff   <= area_in;
      min_x_ff  <= min_x_in;
      max_x_ff  <= max_x_in;
      min_y_ff  <= min_y_in;
      max_y_ff  <= max_y_in;
      count_ff  <= count_in;
      ovf_ff    <= ovf_in;
      o_word_ff <= o_word_in;
   end

   assign out_valid = o_valid_ff;
   assign out_word  = o_word_ff;

endmodule

// File: sim/polygon_area_and_bounds_core_tb.sv
// Self-checking testbench for polygon_area_and_bounds_core: random polygons, shoelace predictor.
module polygon_area_and_bounds_core_tb;

   localparam int COORD_W        = pab_pkg::COORD_W;
   localparam int AREA_W         = pab_pkg::AREA_W;
   localparam int COUNT_FIELD_W  = pab_pkg::COUNT_FIELD_W;
   localparam int MAX_VERTICES   = 1024;
   localparam int COUNT_SHOWN_MAX = 2 ** COUNT_FIELD_W - 1;
   localparam int RANDOM_WORDS   = 1800;
   localparam int LONG_HOLD      = 400;
   localparam int CYCLE_LIMIT    = 200000;

   typedef enum int {COORD_FULL, COORD_NEAR, COORD_CORNER} coord_mode_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } vertex_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   logic quiet;

   pab_req_if req_ch ();
   pab_rsp_if rsp_ch ();

   polygon_area_and_bounds_core #(.MAX_VERTICES(MAX_VERTICES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   vertex_word_type           vertex_backlog[$];
   pab_pkg::result_word_type  polygons_due[$];
   int                      vertices_sent    = 0;
   int                      polygons_checked = 0;
   int                      mismatches       = 0;

   // predictor state
   logic signed [COORD_W-1:0] open_first_x, open_first_y, open_prev_x, open_prev_y;
   logic signed [COORD_W-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
   logic        [AREA_W-1:0]  shoelace_acc;
   int                        open_count;
   logic                      open_overflow;

   function automatic logic [AREA_W-1:0] shoelace_term(input logic signed [COORD_W-1:0] ax,
                                                       input logic signed [COORD_W-1:0] ay,
                                                       input logic signed [COORD_W-1:0] bx,
                                                       input logic signed [COORD_W-1:0] by);
      longint t;
      t = (longint'(ax) + longint'(bx)) * (longint'(ay) - longint'(by));
      return t[AREA_W-1:0];
   endfunction

   task automatic clear_polygon();
      open_first_x  = '0;
      open_first_y  = '0;
      open_prev_x   = '0;
      open_prev_y   = '0;
      box_lo_x      = '0;
      box_hi_x      = '0;
      box_lo_y      = '0;
      box_hi_y      = '0;
      shoelace_acc  = '0;
      open_count    = 0;
      open_overflow = 1'b0;
   endtask

   task automatic absorb_vertex(input vertex_word_type v);
      pab_pkg::result_word_type r;
      if (open_count == 0) begin
         open_first_x  = v.x;
         open_first_y  = v.y;
         box_lo_x      = v.x;
         box_hi_x      = v.x;
         box_lo_y      = v.y;
         box_hi_y      = v.y;
         shoelace_acc  = '0;
         open_overflow = 1'b0;
         open_count    = 1;
      end else begin
         shoelace_acc = shoelace_acc + shoelace_term(open_prev_x, open_prev_y, v.x, v.y);
         if (v.x < box_lo_x) box_lo_x = v.x;
         if (v.x > box_hi_x) box_hi_x = v.x;
         if (v.y < box_lo_y) box_lo_y = v.y;
         if (v.y > box_hi_y) box_hi_y = v.y;
         if (open_count >= MAX_VERTICES) open_overflow = 1'b1;
         else open_count++;
      end
      open_prev_x = v.x;
      open_prev_y = v.y;
      if (v.last) begin
         shoelace_acc   = shoelace_acc + shoelace_term(v.x, v.y, open_first_x, open_first_y);
         r.area_doubled = -shoelace_acc;
         r.min_x        = box_lo_x;
         r.max_x        = box_hi_x;
         r.min_y        = box_lo_y;
         r.max_y        = box_hi_y;
         r.vertex_count = COUNT_FIELD_W'(open_count > COUNT_SHOWN_MAX ? COUNT_SHOWN_MAX
                                                                    : open_count);
         r.too_many     = open_overflow;
         polygons_due.insert(polygons_due.size(), r);
         clear_polygon();
      end
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord(input coord_mode_type mode);
      logic signed [COORD_W-1:0] corners[7];
      corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
      case (mode)
         COORD_NEAR:   return COORD_W'($urandom_range(0, 400)) - 16'sd200;
         COORD_CORNER: return corners[$urandom_range(0, 6)];
         default:      return COORD_W'($urandom);
      endcase
   endfunction

   task automatic push_vertex(input int x, input int y, input logic last);
      vertex_word_type v;
      v.x    = COORD_W'(x);
      v.y    = COORD_W'(y);
      v.last = last;
      vertex_backlog.insert(vertex_backlog.size(), v);
   endtask

   task automatic push_polygon(input int n, input coord_mode_type mode);
      for (int i = 0; i < n; i++)
         push_vertex(pick_coord(mode), pick_coord(mode), i == n - 1);
   endtask

   assign quiet = (cycle_count >= 2000) && (cycle_count < 4000);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // vertex driver
   always @(posedge clock) begin : drive_vertices
      vertex_word_type nxt;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.vertex_x    <= '0;
         req_ch.vertex_y    <= '0;
         req_ch.last_vertex <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            nxt.x    = req_ch.vertex_x;
            nxt.y    = req_ch.vertex_y;
            nxt.last = req_ch.last_vertex;
            absorb_vertex(nxt);
            vertices_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (vertex_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 13)) begin
               nxt = vertex_backlog.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.vertex_x    <= nxt.x;
               req_ch.vertex_y    <= nxt.y;
               req_ch.last_vertex <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   int hold_left = 0;
   bit hold_done = 0;

   always @(posedge clock) begin : check_results
      pab_pkg::result_word_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (polygons_due.size() == 0) begin
               $error("unexpected result word, area_doubled %0d", rsp_ch.area_doubled);
               mismatches++;
            end else begin
               e = polygons_due.pop_front();
               if (rsp_ch.area_doubled !== e.area_doubled) begin
                  $error("area_doubled: expected %0d, got %0d", e.area_doubled,
                         rsp_ch.area_doubled);
                  mismatches++;
               end
               if (rsp_ch.min_x !== e.min_x) begin
                  $error("min_x: expected %0d, got %0d", e.min_x, rsp_ch.min_x);
                  mismatches++;
               end
               if (rsp_ch.max_x !== e.max_x) begin
                  $error("max_x: expected %0d, got %0d", e.max_x, rsp_ch.max_x);
                  mismatches++;
               end
               if (rsp_ch.min_y !== e.min_y) begin
                  $error("min_y: expected %0d, got %0d", e.min_y, rsp_ch.min_y);
                  mismatches++;
               end
               if (rsp_ch.max_y !== e.max_y) begin
                  $error("max_y: expected %0d, got %0d", e.max_y, rsp_ch.max_y);
                  mismatches++;
               end
               if (rsp_ch.vertex_count !== e.vertex_count) begin
                  $error("vertex_count: expected %0d, got %0d", e.vertex_count,
                         rsp_ch.vertex_count);
                  mismatches++;
               end
               if (rsp_ch.too_many !== e.too_many) begin
                  $error("too_many: expected %0d, got %0d", e.too_many, rsp_ch.too_many);
                  mismatches++;
               end
            end
            polygons_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && polygons_checked >= 25) begin
            // long back-pressure: vertex queue fills and intake stalls
            hold_done = 1;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   initial begin
      int  random_words;
      int  n;
      bit  big_done;
      clear_polygon();

      // single-vertex polygons at opposite corners
      push_vertex(-32768, 32767, 1'b1);
      push_vertex(32767, -32768, 1'b1);
      // full-range square, both windings
      push_vertex(-32768, -32768, 1'b0);
      push_vertex(-32768, 32767, 1'b0);
      push_vertex(32767, 32767, 1'b0);
      push_vertex(32767, -32768, 1'b1);
      push_vertex(-32768, -32768, 1'b0);
      push_vertex(32767, -32768, 1'b0);
      push_vertex(32767, 32767, 1'b0);
      push_vertex(-32768, 32767, 1'b1);
      // collinear and two-vertex polygons (zero area), and a right triangle
      push_vertex(0, 0, 1'b0);
      push_vertex(5, 5, 1'b0);
      push_vertex(10, 10, 1'b1);
      push_vertex(0, 0, 1'b0);
      push_vertex(4, 0, 1'b0);
      push_vertex(0, 3, 1'b1);
      push_vertex(1, -1, 1'b0);
      push_vertex(-1, 1, 1'b1);

      random_words = 0;
      big_done     = 0;
      while (random_words < RANDOM_WORDS) begin
         if (!big_done && random_words >= 300) begin
            // one past the vertex limit: count saturates, overflow flag set
            n = MAX_VERTICES + 1;
            big_done = 1;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         end
         push_polygon(n, coord_mode_type'($urandom_range(0, 2)));
         random_words += n;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (vertex_backlog.size() != 0 || req_ch.valid || polygons_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d vertex words accepted, %0d polygon results checked, %0d mismatches",
               vertices_sent, polygons_checked, mismatches);
      $display("covered single-vertex, collinear, full-range and over-%0d-vertex polygons",
               MAX_VERTICES);
      if (mismatches == 0 && polygons_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
